// ----- rtl/core/lmls_pkg.sv -----
package lmls_pkg;

  localparam int ACC_W   = 10;
  localparam int LINE_W  = 8;
  localparam int CLK_W   = 8;
  localparam int MODE_W  = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 8;

  typedef enum logic [1:0] {
    PH_OAM    = 2'd0,
    PH_XFER   = 2'd1,
    PH_HBLANK = 2'd2,
    PH_VBLANK = 2'd3
  } phase_t;

  localparam logic [MODE_W-1:0] MODE_HBLANK = 2'd0;
  localparam logic [MODE_W-1:0] MODE_VBLANK = 2'd1;
  localparam logic [MODE_W-1:0] MODE_OAM    = 2'd2;
  localparam logic [MODE_W-1:0] MODE_XFER   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_COMPARE_LINE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HBLANK_IRQ   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MATCH_IRQ    = 2'd2;

  typedef struct packed {
    phase_t              phase;
    logic [ACC_W-1:0]    acc;
    logic [LINE_W-1:0]   line;
    logic                match;
  } seq_state_t;

  typedef struct packed {
    logic [LINE_W-1:0]   compare_line;
    logic                hblank_irq_enable;
    logic                match_irq_enable;
  } seq_cfg_t;

  typedef struct packed {
    logic [MODE_W-1:0]   lcd_mode;
    logic [LINE_W-1:0]   current_line;
    logic                line_match;
    logic                stat_irq;
    logic                vblank_irq;
    logic                render_valid;
    logic [LINE_W-1:0]   render_line;
    logic                frame_done;
  } seq_result_t;

  function automatic logic [MODE_W-1:0] mode_of(input phase_t ph);
    logic [MODE_W-1:0] m;
    case (ph)
      PH_OAM:    m = MODE_OAM;
      PH_XFER:   m = MODE_XFER;
      PH_HBLANK: m = MODE_HBLANK;
      PH_VBLANK: m = MODE_VBLANK;
      default:   m = MODE_OAM;
    endcase
    return m;
  endfunction

endpackage

// ----- rtl/core/lcd_mode_line_sequencer.sv -----
// Channel  Direction  Handshake           Payload
// in       input      in_valid/in_stall   in_elapsed_clocks
// out      output     out_valid/out_stall lcd_mode, line, flags, render line
// cfg      input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// One item per cycle sustained while the output is not stalled; each accepted item is
// held in the input register, then the step logic writes it into the result register.
// The phase/accumulator update is a single compare plus a constant modulo.
// Synchronous active-low reset: oam scan phase, counters, flags and config zero; data and result regs not reset.
// An output stall holds the result; one more item is then buffered at the input.
module lcd_mode_line_sequencer #(
  parameter int OAM_CLOCKS      = 80,
  parameter int TRANSFER_CLOCKS = 172,
  parameter int HBLANK_CLOCKS   = 204,
  parameter int LINE_CLOCKS     = 456,
  parameter int VISIBLE_LINES   = 144,
  parameter int TOTAL_LINES     = 154
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [lmls_pkg::CLK_W-1:0]          in_elapsed_clocks,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [lmls_pkg::MODE_W-1:0]         out_lcd_mode,
  output logic [lmls_pkg::LINE_W-1:0]         out_current_line,
  output logic                                out_line_match,
  output logic                                out_stat_irq,
  output logic                                out_vblank_irq,
  output logic                                out_render_valid,
  output logic [lmls_pkg::LINE_W-1:0]         out_render_line,
  output logic                                out_frame_done,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lmls_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lmls_pkg::CFG_DAT_W-1:0]      cfg_data
);

  logic                          in_full_r;
  logic [lmls_pkg::CLK_W-1:0]    in_elapsed_r;
  logic                          out_valid_r;
  lmls_pkg::seq_result_t         out_r;
  lmls_pkg::seq_state_t          state_r, state_nxt;
  lmls_pkg::seq_cfg_t            cfg_r;
  lmls_pkg::seq_result_t         res_nxt;
  logic                          advance;
  logic                          in_acc;

  assign advance   = in_full_r && (!out_valid_r || !out_stall);
  assign in_stall  = in_full_r && !advance;
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  lmls_step #(
    .OAM_CLOCKS(OAM_CLOCKS),
    .TRANSFER_CLOCKS(TRANSFER_CLOCKS),
    .HBLANK_CLOCKS(HBLANK_CLOCKS),
    .LINE_CLOCKS(LINE_CLOCKS),
    .VISIBLE_LINES(VISIBLE_LINES),
    .TOTAL_LINES(TOTAL_LINES)
  ) u_step (
    .cur(state_r),
    .cfg(cfg_r),
    .elapsed(in_elapsed_r),
    .nxt(state_nxt),
    .res(res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_full_r         <= 1'b0;
      out_valid_r       <= 1'b0;
      state_r.phase     <= lmls_pkg::PH_OAM;
      state_r.acc       <= '0;
      state_r.line      <= '0;
      state_r.match     <= 1'b0;
      cfg_r             <= '0;
    end else begin
      if (in_acc) begin
        in_full_r <= 1'b1;
      end else if (advance) begin
        in_full_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        state_r     <= state_nxt;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid) begin
        case (cfg_index)
          lmls_pkg::REG_COMPARE_LINE: cfg_r.compare_line      <= cfg_data;
          lmls_pkg::REG_HBLANK_IRQ:   cfg_r.hblank_irq_enable <= cfg_data[0];
          lmls_pkg::REG_MATCH_IRQ:    cfg_r.match_irq_enable  <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_elapsed_r <= in_elapsed_clocks;
    end
    if (advance) begin
      out_r <= res_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_lcd_mode     = out_r.lcd_mode;
  assign out_current_line = out_r.current_line;
  assign out_line_match   = out_r.line_match;
  assign out_stat_irq     = out_r.stat_irq;
  assign out_vblank_irq   = out_r.vblank_irq;
  assign out_render_valid = out_r.render_valid;
  assign out_render_line  = out_r.render_line;
  assign out_frame_done   = out_r.frame_done;

endmodule

// ----- rtl/core/lmls_mod_const.sv -----
module lmls_mod_const #(
  parameter int DIVISOR = 80
) (
  input  logic [lmls_pkg::ACC_W-1:0] acc,
  output logic [lmls_pkg::ACC_W-1:0] rem
);

  localparam int ACC_W  = lmls_pkg::ACC_W;
  localparam int SHIFT  = 2 * ACC_W;
  localparam int RECIP_W = SHIFT + 1;
  localparam int PROD_W = ACC_W + RECIP_W;
  localparam int RECIP  = ((1 << SHIFT) + DIVISOR - 1) / DIVISOR;

  logic [PROD_W-1:0]   prod;
  logic [ACC_W-1:0]    quo;
  logic [2*ACC_W-1:0]  back;

  // reciprocal is exact for every acc value at this shift
  assign prod = PROD_W'(acc) * PROD_W'(RECIP);
  assign quo  = prod[SHIFT+ACC_W-1:SHIFT];
  assign back = (2*ACC_W)'(quo) * (2*ACC_W)'(DIVISOR);
  assign rem  = acc - back[ACC_W-1:0];

endmodule

// ----- rtl/core/lmls_step.sv -----
module lmls_step #(
  parameter int OAM_CLOCKS      = 80,
  parameter int TRANSFER_CLOCKS = 172,
  parameter int HBLANK_CLOCKS   = 204,
  parameter int LINE_CLOCKS     = 456,
  parameter int VISIBLE_LINES   = 144,
  parameter int TOTAL_LINES     = 154
) (
  input  lmls_pkg::seq_state_t              cur,
  input  lmls_pkg::seq_cfg_t                cfg,
  input  logic [lmls_pkg::CLK_W-1:0]        elapsed,
  output lmls_pkg::seq_state_t              nxt,
  output lmls_pkg::seq_result_t             res
);

  localparam int ACC_W  = lmls_pkg::ACC_W;
  localparam int LINE_W = lmls_pkg::LINE_W;

  logic [ACC_W-1:0]  acc;
  logic [ACC_W-1:0]  rem_oam, rem_xfer, rem_hblank, rem_line;
  logic [LINE_W-1:0] line_inc;
  logic              is_match;

  assign acc      = cur.acc + ACC_W'(elapsed);
  assign line_inc = cur.line + LINE_W'(1);
  assign is_match = (cur.line == cfg.compare_line);

  lmls_mod_const #(.DIVISOR(OAM_CLOCKS))      u_mod_oam    (.acc(acc), .rem(rem_oam));
  lmls_mod_const #(.DIVISOR(TRANSFER_CLOCKS)) u_mod_xfer   (.acc(acc), .rem(rem_xfer));
  lmls_mod_const #(.DIVISOR(HBLANK_CLOCKS))   u_mod_hblank (.acc(acc), .rem(rem_hblank));
  lmls_mod_const #(.DIVISOR(LINE_CLOCKS))     u_mod_line   (.acc(acc), .rem(rem_line));

  always_comb begin
    nxt = cur;
    nxt.acc = acc;
    res.stat_irq     = 1'b0;
    res.vblank_irq   = 1'b0;
    res.render_valid = 1'b0;
    res.render_line  = '0;
    res.frame_done   = 1'b0;
    case (cur.phase)
      lmls_pkg::PH_OAM: begin
        if (acc >= ACC_W'(OAM_CLOCKS)) begin
          nxt.acc   = rem_oam;
          nxt.phase = lmls_pkg::PH_XFER;
        end
      end
      lmls_pkg::PH_XFER: begin
        if (acc >= ACC_W'(TRANSFER_CLOCKS)) begin
          nxt.acc      = rem_xfer;
          nxt.match    = is_match;
          res.stat_irq = cfg.hblank_irq_enable || (cfg.match_irq_enable && is_match);
          nxt.phase    = lmls_pkg::PH_HBLANK;
        end
      end
      lmls_pkg::PH_HBLANK: begin
        if (acc >= ACC_W'(HBLANK_CLOCKS)) begin
          nxt.acc          = rem_hblank;
          res.render_valid = 1'b1;
          res.render_line  = cur.line;
          nxt.line         = line_inc;
          if (line_inc < LINE_W'(VISIBLE_LINES)) begin
            nxt.phase = lmls_pkg::PH_OAM;
          end else begin
            res.vblank_irq = 1'b1;
            nxt.phase      = lmls_pkg::PH_VBLANK;
          end
        end
      end
      default: begin
        if (acc >= ACC_W'(LINE_CLOCKS)) begin
          nxt.acc  = rem_line;
          nxt.line = line_inc;
          if (line_inc >= LINE_W'(TOTAL_LINES)) begin
            nxt.line       = '0;
            res.frame_done = 1'b1;
            nxt.phase      = lmls_pkg::PH_OAM;
          end
        end
      end
    endcase
    res.lcd_mode     = lmls_pkg::mode_of(nxt.phase);
    res.current_line = nxt.line;
    res.line_match   = nxt.match;
  end

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import lmls_pkg::*;

  localparam int OAM_LEN      = 80;
  localparam int XFER_LEN     = 172;
  localparam int HBLANK_LEN   = 204;
  localparam int LINE_LEN     = 456;
  localparam int VISIBLE_CNT  = 144;
  localparam int TOTAL_CNT    = 154;
  localparam int STALL_LIMIT  = 2000;
  localparam int LONG_HOLD    = 60;
  localparam int SETTLE_CYCLES = 4;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  class line_timing_scoreboard;
    phase_t            ph;
    logic [ACC_W-1:0]  acc;
    logic [LINE_W-1:0] line_ctr;
    logic              match;
    logic [LINE_W-1:0] cmp_line;
    logic              hb_en;
    logic              m_en;
    seq_result_t       expected_q[$];
    int                errors;

    function new();
      ph       = PH_OAM;
      acc      = '0;
      line_ctr = '0;
      match    = 1'b0;
      cmp_line = '0;
      hb_en    = 1'b0;
      m_en     = 1'b0;
      errors   = 0;
    endfunction

    function void write_register(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [CFG_DAT_W-1:0] data);
      case (idx)
        REG_COMPARE_LINE: cmp_line = data;
        REG_HBLANK_IRQ:   hb_en = data[0];
        REG_MATCH_IRQ:    m_en = data[0];
        default: ;
      endcase
    endfunction

    function void note_clocks(input logic [CLK_W-1:0] clocks);
      int          total;
      seq_result_t want;
      total = int'(acc) + int'(clocks);
      want = '0;
      case (ph)
        PH_OAM: begin
          if (total >= OAM_LEN) begin
            total = total % OAM_LEN;
            ph = PH_XFER;
          end
        end
        PH_XFER: begin
          if (total >= XFER_LEN) begin
            total = total % XFER_LEN;
            match = (line_ctr == cmp_line);
            want.stat_irq = hb_en || (m_en && match);
            ph = PH_HBLANK;
          end
        end
        PH_HBLANK: begin
          if (total >= HBLANK_LEN) begin
            total = total % HBLANK_LEN;
            want.render_valid = 1'b1;
            want.render_line = line_ctr;
            line_ctr = line_ctr + 1'b1;
            if (line_ctr < VISIBLE_CNT) begin
              ph = PH_OAM;
            end else begin
              want.vblank_irq = 1'b1;
              ph = PH_VBLANK;
            end
          end
        end
        default: begin
          if (total >= LINE_LEN) begin
            total = total % LINE_LEN;
            line_ctr = line_ctr + 1'b1;
            if (line_ctr >= TOTAL_CNT) begin
              line_ctr = '0;
              want.frame_done = 1'b1;
              ph = PH_OAM;
            end
          end
        end
      endcase
      acc = ACC_W'(total);
      case (ph)
        PH_OAM:    want.lcd_mode = MODE_OAM;
        PH_XFER:   want.lcd_mode = MODE_XFER;
        PH_HBLANK: want.lcd_mode = MODE_HBLANK;
        default:   want.lcd_mode = MODE_VBLANK;
      endcase
      want.current_line = line_ctr;
      want.line_match = match;
      expected_q.push_back(want);
    endfunction

    function void compare_field(input string name, input logic [7:0] want,
                                input logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(input seq_result_t got);
      seq_result_t want;
      if (expected_q.size() == 0) begin
        $error("result item arrived with none expected");
        errors++;
        return;
      end
      want = expected_q.pop_front();
      compare_field("lcd_mode", 8'(want.lcd_mode), 8'(got.lcd_mode));
      compare_field("current_line", want.current_line, got.current_line);
      compare_field("line_match", 8'(want.line_match), 8'(got.line_match));
      compare_field("stat_irq", 8'(want.stat_irq), 8'(got.stat_irq));
      compare_field("vblank_irq", 8'(want.vblank_irq), 8'(got.vblank_irq));
      compare_field("render_valid", 8'(want.render_valid), 8'(got.render_valid));
      compare_field("render_line", want.render_line, got.render_line);
      compare_field("frame_done", 8'(want.frame_done), 8'(got.frame_done));
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [CLK_W-1:0]      in_elapsed_clocks = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [MODE_W-1:0]     out_lcd_mode;
  logic [LINE_W-1:0]     out_current_line;
  logic                  out_line_match;
  logic                  out_stat_irq;
  logic                  out_vblank_irq;
  logic                  out_render_valid;
  logic [LINE_W-1:0]     out_render_line;
  logic                  out_frame_done;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DAT_W-1:0]  cfg_data = '0;

  line_timing_scoreboard board = new();

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  byte unsigned corner_clocks[20] = '{8'd0, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd1,
                                      8'd128, 8'd127, 8'd254, 8'd170, 8'd85, 8'd255,
                                      8'd255, 8'd255, 8'd0, 8'd2, 8'd4, 8'd8, 8'd16};

  lcd_mode_line_sequencer DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_elapsed_clocks (in_elapsed_clocks),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_lcd_mode      (out_lcd_mode),
    .out_current_line  (out_current_line),
    .out_line_match    (out_line_match),
    .out_stat_irq      (out_stat_irq),
    .out_vblank_irq    (out_vblank_irq),
    .out_render_valid  (out_render_valid),
    .out_render_line   (out_render_line),
    .out_frame_done    (out_frame_done),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always #6 clk = ~clk;

  always @(negedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= LONG_HOLD;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    seq_result_t got;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      got = '{lcd_mode: out_lcd_mode, current_line: out_current_line,
              line_match: out_line_match, stat_irq: out_stat_irq,
              vblank_irq: out_vblank_irq, render_valid: out_render_valid,
              render_line: out_render_line, frame_done: out_frame_done};
      board.check_result(got);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall) ||
        (cfg_valid && cfg_ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DAT_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    board.write_register(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_clocks(input logic [CLK_W-1:0] clocks);
    @(negedge clk);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_elapsed_clocks <= clocks;
    do @(posedge clk); while (in_stall !== 1'b0);
    board.note_clocks(clocks);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.pending() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_segment(input int count, input int tx_pct, input int rx_pct,
                             input bit with_hold);
    logic [CLK_W-1:0] clocks;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (int i = 0; i < count; i++) begin
      if (with_hold && i == 50) hold_req++;
      // bias toward long steps so the run reaches vblank and wraps the frame
      if ($urandom_range(0, 9) < 6) clocks = CLK_W'($urandom_range(160, 255));
      else clocks = CLK_W'($urandom_range(0, 255));
      send_clocks(clocks);
    end
    drain();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    write_register(REG_COMPARE_LINE, 8'd0);
    write_register(REG_HBLANK_IRQ, 8'hFE);
    write_register(REG_MATCH_IRQ, 8'h01);
    write_register(REG_SPARE, 8'hFF);
    tx_idle_pct = 30;
    rx_idle_pct = 76;
    foreach (corner_clocks[i]) send_clocks(corner_clocks[i]);
    drain();

    write_register(REG_COMPARE_LINE, CFG_DAT_W'($urandom_range(5, 60)));
    write_register(REG_HBLANK_IRQ, 8'h00);
    write_register(REG_MATCH_IRQ, 8'hFF);
    run_segment(200, 30, 76, 1'b0);

    write_register(REG_COMPARE_LINE, 8'd255);
    write_register(REG_HBLANK_IRQ, 8'h01);
    write_register(REG_MATCH_IRQ, 8'h02);
    run_segment(200, 76, 30, 1'b0);

    write_register(REG_COMPARE_LINE, CFG_DAT_W'($urandom_range(0, 143)));
    write_register(REG_HBLANK_IRQ, 8'hFF);
    write_register(REG_MATCH_IRQ, 8'h01);
    run_segment(200, 0, 0, 1'b1);

    if (board.pending() != 0) begin
      $error("%0d expected result items never arrived", board.pending());
      board.errors++;
    end
    if (board.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
